### rtl/segment_box_edge_collision_unit_defines.svh
// Assertion helpers shared by the collision unit
`ifndef SEGMENT_BOX_EDGE_COLLISION_UNIT_DEFINES_SVH
`define SEGMENT_BOX_EDGE_COLLISION_UNIT_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define SBEC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check
`define SBEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sbec_pkg.sv
package sbec_pkg;

  // Coordinate and box extent widths
  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = 10;
  // Far corner (corner plus extent) never wraps
  localparam int EDGE_W     = ((COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS) + 1;
  localparam int DIFF_W     = EDGE_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SGN_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [EXT_BITS-1:0] BOX_WIDTH_RST  = EXT_BITS'(20);
  localparam logic [EXT_BITS-1:0] BOX_HEIGHT_RST = EXT_BITS'(35);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [EXT_BITS-1:0]   ext_t;
  typedef logic signed [EDGE_W-1:0]     edge_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SGN_W-1:0]      sgn_t;

  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_NEG  = 2'd1,
    SGN_POS  = 2'd2
  } sign_t;

  // One segment and box corner
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t left;
    coord_t top;
  } seg_t;

  // After the difference stage
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t cx_l;
    diff_t cx_r;
    diff_t cy_t;
    diff_t cy_b;
    sign_t sl_s;
    sign_t sl_e;
    sign_t sr_s;
    sign_t sr_e;
    sign_t st_s;
    sign_t st_e;
    sign_t sb_s;
    sign_t sb_e;
    logic  w_nz;
    logic  h_nz;
  } s1_t;

  // After the product stage
  typedef struct packed {
    prod_t p_yl;
    prod_t p_yr;
    prod_t p_xt;
    prod_t p_xb;
    logic  es_left;
    logic  es_right;
    logic  es_top;
    logic  es_bot;
  } s2_t;

  // After the orientation stage
  typedef struct packed {
    sign_t o_lt;
    sign_t o_rt;
    sign_t o_lb;
    sign_t o_rb;
    logic  es_left;
    logic  es_right;
    logic  es_top;
    logic  es_bot;
  } s3_t;

  function automatic sign_t sign_of(input sgn_t v);
    if (v == '0) begin
      return SGN_ZERO;
    end else if (v[SGN_W-1]) begin
      return SGN_NEG;
    end else begin
      return SGN_POS;
    end
  endfunction

endpackage

### rtl/sbec_ifs.sv
// Segment input channel
interface sbec_seg_if import sbec_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_end_x;
  coord_t seg_end_y;
  coord_t box_left;
  coord_t box_top;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  box_left, box_top, input ready);
  modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  box_left, box_top, output ready);
endinterface

// Result channel
interface sbec_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

// Register write channel
interface sbec_cfg_if import sbec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  ext_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sbec_diff.sv
module sbec_diff import sbec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  seg_t in_data,
  input  ext_t box_width,
  input  ext_t box_height,
  output logic out_valid,
  input  logic out_ready,
  output s1_t  out_data
);

  edge_t right;
  edge_t bottom;
  s1_t   data_next;

  // Far corner and offsets from the segment end
  always_comb begin
    right  = edge_t'(in_data.left) + edge_t'(box_width);
    bottom = edge_t'(in_data.top) + edge_t'(box_height);

    data_next.dx   = diff_t'(in_data.ex) - diff_t'(in_data.sx);
    data_next.dy   = diff_t'(in_data.ey) - diff_t'(in_data.sy);
    data_next.cx_l = diff_t'(in_data.left) - diff_t'(in_data.ex);
    data_next.cx_r = diff_t'(right) - diff_t'(in_data.ex);
    data_next.cy_t = diff_t'(in_data.top) - diff_t'(in_data.ey);
    data_next.cy_b = diff_t'(bottom) - diff_t'(in_data.ey);

    // Side of each endpoint relative to each edge line
    data_next.sl_s = sign_of(sgn_t'(in_data.sx) - sgn_t'(in_data.left));
    data_next.sl_e = sign_of(sgn_t'(in_data.ex) - sgn_t'(in_data.left));
    data_next.sr_s = sign_of(sgn_t'(in_data.sx) - sgn_t'(right));
    data_next.sr_e = sign_of(sgn_t'(in_data.ex) - sgn_t'(right));
    data_next.st_s = sign_of(sgn_t'(in_data.sy) - sgn_t'(in_data.top));
    data_next.st_e = sign_of(sgn_t'(in_data.ey) - sgn_t'(in_data.top));
    data_next.sb_s = sign_of(sgn_t'(in_data.sy) - sgn_t'(bottom));
    data_next.sb_e = sign_of(sgn_t'(in_data.ey) - sgn_t'(bottom));

    data_next.w_nz = (box_width != '0);
    data_next.h_nz = (box_height != '0);
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the stage when it is empty or the next one can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/sbec_mul.sv
module sbec_mul import sbec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  s2_t data_next;

  // Four distinct cross-product terms serve all four corners
  always_comb begin
    data_next.p_yl = prod_t'(in_data.dy) * prod_t'(in_data.cx_l);
    data_next.p_yr = prod_t'(in_data.dy) * prod_t'(in_data.cx_r);
    data_next.p_xt = prod_t'(in_data.dx) * prod_t'(in_data.cy_t);
    data_next.p_xb = prod_t'(in_data.dx) * prod_t'(in_data.cy_b);

    // Edge orientation of the endpoints differs only on a nondegenerate edge
    data_next.es_left  = in_data.h_nz && (in_data.sl_s != in_data.sl_e);
    data_next.es_right = in_data.h_nz && (in_data.sr_s != in_data.sr_e);
    data_next.es_top   = in_data.w_nz && (in_data.st_s != in_data.st_e);
    data_next.es_bot   = in_data.w_nz && (in_data.sb_s != in_data.sb_e);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/sbec_orient.sv
module sbec_orient import sbec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s2_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s3_t  out_data
);

  s3_t data_next;

  // Orientation of each box corner against the segment
  always_comb begin
    data_next.o_lt = sign_of(sgn_t'(in_data.p_yl) - sgn_t'(in_data.p_xt));
    data_next.o_rt = sign_of(sgn_t'(in_data.p_yr) - sgn_t'(in_data.p_xt));
    data_next.o_lb = sign_of(sgn_t'(in_data.p_yl) - sgn_t'(in_data.p_xb));
    data_next.o_rb = sign_of(sgn_t'(in_data.p_yr) - sgn_t'(in_data.p_xb));
    data_next.es_left  = in_data.es_left;
    data_next.es_right = in_data.es_right;
    data_next.es_top   = in_data.es_top;
    data_next.es_bot   = in_data.es_bot;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/segment_box_edge_collision_unit.sv
// Segment versus box edge collision unit.
// seg channel: one transaction carries a segment (start and end point) and the
//   top-left corner of an axis-aligned box, all signed whole pixels.
// res channel: one transaction per segment, hit = 1 when the segment crosses
//   or touches any of the four box edges; collinear overlap does not count.
// cfg channel: register writes, index 0 = box width, index 1 = box height;
//   other indexes are dropped. ready is always high. Write only while idle.
// Path: seg acceptance to res valid runs through the difference, multiply,
//   orientation and result register stages.
// Throughput: one transaction per cycle while res is not stalled; every stage
//   of the four-deep pipeline holds one item.
// Stall: each stage loads when it is empty or the stage after it moves, so
//   bubbles fill while res is stalled and seg.ready drops only when all four
//   stages are full. Nothing is lost or repeated.
// Reset: synchronous, clears all valid bits and sets width 20, height 35.
`include "segment_box_edge_collision_unit_defines.svh"

module segment_box_edge_collision_unit import sbec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sbec_seg_if.sink   seg,
  sbec_cfg_if.sink   cfg,
  sbec_hit_if.source res
);

  ext_t box_width;
  ext_t box_height;
  seg_t seg_data;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;
  logic s3_valid;
  logic s3_ready;
  s3_t  s3_data;
  logic hit_next;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= BOX_WIDTH_RST;
      box_height <= BOX_HEIGHT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_BOX_WIDTH:  box_width <= cfg.data;
        CFG_BOX_HEIGHT: box_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pack the incoming transaction
  always_comb begin
    seg_data.sx   = seg.seg_start_x;
    seg_data.sy   = seg.seg_start_y;
    seg_data.ex   = seg.seg_end_x;
    seg_data.ey   = seg.seg_end_y;
    seg_data.left = seg.box_left;
    seg_data.top  = seg.box_top;
  end

  sbec_diff u_diff (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (seg.valid),
    .in_ready   (seg.ready),
    .in_data    (seg_data),
    .box_width  (box_width),
    .box_height (box_height),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  sbec_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  sbec_orient u_orient (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // An edge is crossed when its end corners lie on different sides of the
  // segment and the segment ends lie on different sides of the edge
  always_comb begin
    hit_next = ((s3_data.o_lt != s3_data.o_lb) && s3_data.es_left)
            || ((s3_data.o_rt != s3_data.o_rb) && s3_data.es_right)
            || ((s3_data.o_lt != s3_data.o_rt) && s3_data.es_top)
            || ((s3_data.o_lb != s3_data.o_rb) && s3_data.es_bot);
  end

  assign s3_ready = !res.valid || res.ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s3_ready) begin
      res.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      res.hit <= hit_next;
    end
  end

  // A box with no extent has only degenerate edges and is never crossed
  `SBEC_ASSERT_IMPL(a_flat_box_no_hit, clk, rst, res.valid && box_width == '0 && box_height == '0, !res.hit, "hit reported for a box of zero size")
  // A width write lands in the register
  `SBEC_ASSERT_NEXT(a_cfg_width, clk, rst, cfg.valid && cfg.ready && cfg.index == CFG_BOX_WIDTH, box_width == $past(cfg.data), "box width write lost")
  // An orientation result waiting on a full output register holds
  `SBEC_ASSERT_NEXT(a_s3_hold, clk, rst, s3_valid && !s3_ready, s3_valid && $stable(s3_data), "orientation stage dropped a held item")

endmodule
